>>> rtl/core/dvr_pkg.sv
`timescale 1ns / 1ps

package dvr_pkg;

	localparam int NODES     = 16;
	localparam int NODE_W    = $clog2(NODES);
	localparam int COST_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 8;

	localparam logic [COST_W-1:0] COST_MAX     = {COST_W{1'b1}};
	localparam logic [COST_W-1:0] DIAMETER_RST = COST_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MY_ID    = 1'b0,
		CFG_DIAMETER = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_ADVERT = 1'b1
	} req_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic              neighbor;
		logic [NODE_W-1:0] hop;
		logic [COST_W-1:0] cost;
	} route_ent_t;

	localparam int ENT_W = $bits(route_ent_t);

endpackage

>>> rtl/core/dvr_ram.sv
`timescale 1ns / 1ps

module dvr_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/distance_vector_route_update_unit.sv
// Distance-vector route update unit. Each item is either a load of a neighbor link
// (req_type 0) or one advertised destination/cost entry (req_type 1); every item gives
// exactly one result. The route table is read for an item in ST_IDLE
// (a duplicated single-port-read RAM, so the sender and destination entries are read
// together); ST_UPDATE then computes and writes the entry back. The next item is taken
// as soon as the write-back cycle ends, while the result waits in the output register;
// the write-back cycle holds only when that register still carries an untaken result.
// Per-entry known and written flags live in flops and clear at reset; an entry that was
// never written reads as zero, so no clearing pass is needed.
// Configuration is taken at any time (cfg_ready is always high).
`timescale 1ns / 1ps

module distance_vector_route_update_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dvr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dvr_pkg::CFG_DW-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [dvr_pkg::NODE_W-1:0]     sender_id,
	input  logic [dvr_pkg::NODE_W-1:0]     adv_dest,
	input  logic [dvr_pkg::COST_W-1:0]     adv_cost,
	input  logic                           neighbor_mark,
	input  logic                           last_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           entry_changed,
	output logic [dvr_pkg::COST_W-1:0]     route_cost_out,
	output logic [dvr_pkg::NODE_W-1:0]     next_hop_out,
	output logic                           entry_skipped,
	output logic                           resend
);

	import dvr_pkg::*;

	state_t state_q, state_n;
	logic   in_fire, upd_fire;

	logic [NODE_W-1:0] my_id_q;
	logic [COST_W-1:0] diameter_q;
	logic [NODES-1:0]  known_q;
	logic [NODES-1:0]  known_set;
	logic [NODES-1:0]  written_q;
	logic              pending_q;

	req_t              type_s1;
	logic [NODE_W-1:0] snd_s1, dst_s1;
	logic [COST_W-1:0] cost_s1;
	logic              mark_s1, last_s1;

	logic [NODE_W-1:0] rd_snd_addr, rd_dst_addr;
	route_ent_t        snd_raw, dst_raw, snd_ent, dst_ent;

	logic              tbl_we;
	logic [NODE_W-1:0] tbl_waddr;
	route_ent_t        tbl_wdata;
	logic              adv_we;

	logic              skip, dst_known, chg, pend_n, rs;
	logic [COST_W:0]   sum_w;
	logic [COST_W-1:0] sum;
	route_ent_t        upd_ent;

	logic              out_valid_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q    <= '0;
			diameter_q <= DIAMETER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MY_ID:    my_id_q    <= cfg_data[NODE_W-1:0];
				CFG_DIAMETER: diameter_q <= cfg_data[COST_W-1:0];
				default:      ;
			endcase
		end
	end

	// control
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_n = ST_UPDATE;
			ST_UPDATE: if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		upd_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_UPDATE: upd_fire = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			type_s1 <= req_t'(req_type);
			snd_s1  <= sender_id;
			dst_s1  <= adv_dest;
			cost_s1 <= adv_cost;
			mark_s1 <= neighbor_mark;
			last_s1 <= last_entry;
		end
	end

	// route table, duplicated for two reads
	assign rd_snd_addr = (state_q == ST_IDLE) ? sender_id : snd_s1;
	assign rd_dst_addr = (state_q == ST_IDLE) ? adv_dest : dst_s1;

	dvr_ram #(.W(ENT_W), .D(NODES)) u_tbl_snd (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (rd_snd_addr),
		.rdata (snd_raw)
	);

	dvr_ram #(.W(ENT_W), .D(NODES)) u_tbl_dst (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (rd_dst_addr),
		.rdata (dst_raw)
	);

	dvr_ram #(.W(COST_W), .D(NODES * NODES)) u_adv_store (
		.clk   (clk),
		.we    (adv_we),
		.waddr ({snd_s1, dst_s1}),
		.wdata (cost_s1),
		.raddr ({snd_s1, dst_s1}),
		.rdata ()
	);

	// entries never written read as zero
	assign snd_ent = written_q[snd_s1] ? snd_raw : '0;
	assign dst_ent = written_q[dst_s1] ? dst_raw : '0;

	// update
	always_comb begin
		skip      = (dst_s1 == my_id_q);
		dst_known = known_q[dst_s1] || (snd_s1 == dst_s1);
		sum_w     = {1'b0, cost_s1} + {1'b0, snd_ent.cost};
		sum       = sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];
		chg       = 1'b0;
		upd_ent   = dst_ent;
		if (!dst_known) begin
			upd_ent.cost = sum;
			upd_ent.hop  = snd_s1;
			chg          = 1'b1;
		end else if (dst_ent.hop == snd_s1 && dst_ent.cost != sum) begin
			if (sum > diameter_q) begin
				upd_ent.cost = diameter_q;
			end else begin
				upd_ent.cost = sum;
				chg          = 1'b1;
			end
		end else if (dst_ent.cost > sum) begin
			upd_ent.cost = sum;
			upd_ent.hop  = snd_s1;
			chg          = 1'b1;
		end
		if (type_s1 == REQ_LOAD || skip) begin
			chg = 1'b0;
		end
		pend_n = pending_q || chg;
		rs     = (type_s1 == REQ_ADVERT) && last_s1 && pend_n;
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = dst_s1;
		tbl_wdata = upd_ent;
		adv_we    = 1'b0;
		if (upd_fire) begin
			if (type_s1 == REQ_LOAD) begin
				tbl_we             = 1'b1;
				tbl_waddr          = snd_s1;
				tbl_wdata.neighbor = mark_s1;
				tbl_wdata.hop      = snd_s1;
				tbl_wdata.cost     = cost_s1;
			end else if (!skip) begin
				tbl_we = 1'b1;
				adv_we = snd_ent.neighbor;
			end
		end
	end

	always_comb begin
		known_set         = '0;
		known_set[snd_s1] = 1'b1;
		if (tbl_we) begin
			known_set[tbl_waddr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q   <= '0;
			pending_q <= 1'b0;
		end else if (upd_fire) begin
			known_q <= known_q | known_set;
			if (type_s1 == REQ_ADVERT) begin
				pending_q <= last_s1 ? 1'b0 : pend_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (tbl_we) begin
			written_q[tbl_waddr] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			entry_changed <= chg;
			entry_skipped <= (type_s1 == REQ_ADVERT) && skip;
			resend        <= rs;
			if (type_s1 == REQ_LOAD) begin
				route_cost_out <= cost_s1;
				next_hop_out   <= snd_s1;
			end else if (skip) begin
				route_cost_out <= dst_ent.cost;
				next_hop_out   <= dst_ent.hop;
			end else begin
				route_cost_out <= upd_ent.cost;
				next_hop_out   <= upd_ent.hop;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("item accepted while an update was in flight");

	a_write_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (state_q == ST_UPDATE) && upd_fire)
		else $error("route table written outside the update cycle");

	a_skip_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_skipped |-> !entry_changed)
		else $error("skipped entry reported as a change");

	a_pending_set: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire && chg && !last_s1 |=> pending_q)
		else $error("change not held for the message end");

	a_update_sees_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid)
		else $error("result lost after update");
`endif

endmodule
